### hdl/sine_taylor_series_macros.svh
// assertion macros for the sine series block
// no dependencies; included by the files that carry assertions
`ifndef SINE_TAYLOR_SERIES_MACROS_SVH
`define SINE_TAYLOR_SERIES_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define STS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define STS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);
`else
`define STS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define STS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### hdl/sts_pkg.sv
// shared types, constants and helpers for the sine series block
// no dependencies; imported by every module of the block
package sts_pkg;

	// number formats
	localparam int INNER_FRAC_BITS = 40;
	localparam int IO_FRAC_BITS    = 28;
	localparam int UP_SH           = INNER_FRAC_BITS - IO_FRAC_BITS;
	localparam int WORD_W          = 48;
	localparam int ANGLE_W         = 32;
	localparam int ACC_W           = 2 * WORD_W;

	// multiplier digit and divider sizes
	localparam int DIG_W     = 16;
	localparam int DIG_IDX_W = 2;
	localparam int DIV_W     = 16;
	localparam int REM_W     = DIV_W + 1;
	localparam int DIV_BITS  = 8;

	// configuration
	localparam int THR_W     = 40;
	localparam int CNT_W     = 7;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 1'd1;
	localparam logic [THR_W-1:0]     THR_RESET     = 40'd10995;
	localparam logic [CNT_W-1:0]     LIMIT_RESET   = 7'd99;

	// input clamp: [-4, 4) in the io format
	localparam logic [ANGLE_W-1:0] ANGLE_LIM = ANGLE_W'(64'd4 << IO_FRAC_BITS);

	// output saturation magnitudes
	localparam logic [WORD_W-1:0] OUT_NEG_MAG = WORD_W'(64'h8000_0000);
	localparam logic [WORD_W-1:0] OUT_POS_MAX = WORD_W'(64'h7FFF_FFFF);

	// microprogram counter
	localparam int PC_W = 4;

	typedef enum logic {OPA_XM, OPA_TERM} opa_t;
	typedef enum logic {OPB_XM, OPB_X2} opb_t;
	typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_MAC} acc_op_t;
	typedef enum logic [2:0] {
		ACT_NONE, ACT_LD_X2, ACT_LD_D, ACT_LD_DIV, ACT_DIV, ACT_TERM, ACT_DONE
	} act_t;
	typedef enum logic [1:0] {JMP_NEXT, JMP_IF_LIMIT, JMP_IF_MORE} jmp_t;

	// one microcode control word
	typedef struct packed {
		opa_t                 a_sel;
		opb_t                 b_sel;
		logic [DIG_IDX_W-1:0] dig;
		acc_op_t              acc_op;
		act_t                 act;
		jmp_t                 jmp;
		logic [PC_W-1:0]      target;
	} ctl_t;

	// datapath status seen by the sequencer
	typedef struct packed {
		logic limit_hit;
		logic more;
	} stat_t;

	// (2i)(2i+1) for i = n+1
	function automatic logic [DIV_W-1:0] term_divisor(input logic [CNT_W-1:0] n);
		logic [CNT_W:0] two_i;
		logic [CNT_W:0] two_i_p1;
		two_i    = {n, 1'b0} + (CNT_W+1)'(2);
		two_i_p1 = two_i + (CNT_W+1)'(1);
		return DIV_W'(DIV_W'(two_i) * DIV_W'(two_i_p1));
	endfunction

endpackage

### hdl/sts_dp.sv
// datapath: 48x16 multiply-accumulate, 8-bit-per-step divider, sum and saturation
// depends on sts_pkg and the assertion macro header
`include "sine_taylor_series_macros.svh"
module sts_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [sts_pkg::ANGLE_W-1:0] angle,
	input  sts_pkg::ctl_t                    ctl,
	input  logic [sts_pkg::THR_W-1:0]        stop_threshold,
	input  logic [sts_pkg::CNT_W-1:0]        term_limit,
	output sts_pkg::stat_t                   stat,
	output logic signed [sts_pkg::ANGLE_W-1:0] sine_value,
	output logic [sts_pkg::CNT_W-1:0]        terms_added,
	output logic                             limit_reached
);
	import sts_pkg::*;

	logic [WORD_W-1:0] xm_q;
	logic [WORD_W-1:0] x2_q;
	logic [WORD_W-1:0] tmag_q;
	logic              tneg_q;
	logic [WORD_W-1:0] sum_q;
	logic [ACC_W-1:0]  acc_q;
	logic [WORD_W-1:0] quo_q;
	logic [REM_W-1:0]  rem_q;
	logic [DIV_W-1:0]  d_q;
	logic [CNT_W-1:0]  n_q;
	logic              thr_stop_q;

	logic              in_neg;
	logic [ANGLE_W-1:0] in_mag;
	logic [ANGLE_W-1:0] in_clamp;
	logic [WORD_W-1:0] in_xm;

	logic [WORD_W-1:0] a_op;
	logic [WORD_W-1:0] b_op;
	logic [DIG_W-1:0]  digit;
	logic [WORD_W+DIG_W-1:0] prod;

	logic [REM_W-1:0]  div_r;
	logic [WORD_W-1:0] div_q;

	logic [WORD_W-1:0] thr_ext;

	logic              s_neg;
	logic [WORD_W-1:0] s_mag;
	logic [WORD_W-1:0] s_sh;
	logic [WORD_W-1:0] s_sat;
	logic [ANGLE_W-1:0] s_mag32;

	// input clamp and widening
	always_comb begin
		in_neg = angle[ANGLE_W-1];
		in_mag = in_neg ? (~angle + ANGLE_W'(1)) : angle;
		if (in_neg) begin
			in_clamp = (in_mag > ANGLE_LIM) ? ANGLE_LIM : in_mag;
		end else begin
			in_clamp = (in_mag > ANGLE_LIM - ANGLE_W'(1)) ? ANGLE_LIM - ANGLE_W'(1) : in_mag;
		end
		in_xm = WORD_W'(in_clamp) << UP_SH;
	end

	// multiplier operands, msb digit first
	always_comb begin
		a_op = (ctl.a_sel == OPA_XM) ? xm_q : tmag_q;
		b_op = (ctl.b_sel == OPB_XM) ? xm_q : x2_q;
		unique case (ctl.dig)
			2'd0:    digit = b_op[DIG_W-1:0];
			2'd1:    digit = b_op[2*DIG_W-1:DIG_W];
			2'd2:    digit = b_op[3*DIG_W-1:2*DIG_W];
			default: digit = '0;
		endcase
		prod = (WORD_W+DIG_W)'(a_op) * (WORD_W+DIG_W)'(digit);
	end

	// restoring division, DIV_BITS quotient bits per step
	always_comb begin
		div_r = rem_q;
		div_q = quo_q;
		for (int k = 0; k < DIV_BITS; k++) begin
			div_r = {div_r[REM_W-2:0], div_q[WORD_W-1]};
			div_q = {div_q[WORD_W-2:0], 1'b0};
			if (div_r >= {1'b0, d_q}) begin
				div_r    = div_r - {1'b0, d_q};
				div_q[0] = 1'b1;
			end
		end
	end

	// loop status
	always_comb begin
		thr_ext        = WORD_W'(stop_threshold);
		stat.limit_hit = (n_q >= term_limit);
		stat.more      = (quo_q > thr_ext) &&
			(({1'b0, n_q} + (CNT_W+1)'(1)) < {1'b0, term_limit});
	end

	always_ff @(posedge clk) begin
		if (start) begin
			xm_q   <= in_xm;
			tmag_q <= in_xm;
			tneg_q <= in_neg;
			sum_q  <= in_neg ? (~in_xm + WORD_W'(1)) : in_xm;
		end
		unique case (ctl.acc_op)
			ACC_LOAD: acc_q <= ACC_W'(prod);
			ACC_MAC:  acc_q <= {acc_q[ACC_W-DIG_W-1:0], {DIG_W{1'b0}}} + ACC_W'(prod);
			default:  acc_q <= acc_q;
		endcase
		unique case (ctl.act)
			ACT_LD_X2: x2_q <= acc_q[INNER_FRAC_BITS +: WORD_W];
			ACT_LD_D:  d_q  <= term_divisor(n_q);
			ACT_LD_DIV: begin
				quo_q <= acc_q[INNER_FRAC_BITS +: WORD_W];
				rem_q <= '0;
			end
			ACT_DIV: begin
				quo_q <= div_q;
				rem_q <= div_r;
			end
			ACT_TERM: begin
				tmag_q <= quo_q;
				tneg_q <= !tneg_q;
				sum_q  <= tneg_q ? (sum_q + quo_q) : (sum_q - quo_q);
			end
			default: ;
		endcase
	end

	// term count and stop reason
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q        <= '0;
			thr_stop_q <= 1'b0;
		end else if (start) begin
			n_q        <= '0;
			thr_stop_q <= 1'b0;
		end else if (ctl.act == ACT_TERM) begin
			n_q        <= n_q + CNT_W'(1);
			thr_stop_q <= (quo_q <= thr_ext);
		end
	end

	// narrow to the io format and saturate
	always_comb begin
		s_neg = sum_q[WORD_W-1];
		s_mag = s_neg ? (~sum_q + WORD_W'(1)) : sum_q;
		s_sh  = s_mag >> UP_SH;
		if (s_neg) begin
			s_sat = (s_sh > OUT_NEG_MAG) ? OUT_NEG_MAG : s_sh;
		end else begin
			s_sat = (s_sh > OUT_POS_MAX) ? OUT_POS_MAX : s_sh;
		end
		s_mag32       = s_sat[ANGLE_W-1:0];
		sine_value    = s_neg ? (~s_mag32 + ANGLE_W'(1)) : s_mag32;
		terms_added   = n_q;
		limit_reached = !thr_stop_q;
	end

	`STS_ASSERT_NXT(a_div_rem_bound, clk, arst_n, ctl.act == ACT_DIV, (rem_q < {1'b0, d_q}), "divider remainder not below divisor")

endmodule

### hdl/sts_seq.sv
// microcode sequencer: program counter, control store and conditional jumps
// depends on sts_pkg and the assertion macro header
`include "sine_taylor_series_macros.svh"
module sts_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           out_free,
	input  sts_pkg::stat_t stat,
	output sts_pkg::ctl_t  ctl,
	output logic           busy,
	output logic           done
);
	import sts_pkg::*;

	localparam logic [PC_W-1:0] PC_LOOP = PC_W'(4);
	localparam logic [PC_W-1:0] PC_FIN  = PC_W'(15);

	logic [PC_W-1:0] pc_q;
	logic            busy_q;
	logic            taken;

	function automatic ctl_t uw(input opa_t a, input opb_t b,
		input logic [DIG_IDX_W-1:0] dig, input acc_op_t op, input act_t act,
		input jmp_t jmp, input logic [PC_W-1:0] tgt);
		ctl_t w;
		w.a_sel  = a;
		w.b_sel  = b;
		w.dig    = dig;
		w.acc_op = op;
		w.act    = act;
		w.jmp    = jmp;
		w.target = tgt;
		return w;
	endfunction

	// control store
	function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
		ctl_t w;
		unique case (pc)
			4'd0:  w = uw(OPA_XM, OPB_XM, 2'd2, ACC_LOAD, ACT_NONE, JMP_NEXT, '0);
			4'd1:  w = uw(OPA_XM, OPB_XM, 2'd1, ACC_MAC, ACT_NONE, JMP_NEXT, '0);
			4'd2:  w = uw(OPA_XM, OPB_XM, 2'd0, ACC_MAC, ACT_NONE, JMP_NEXT, '0);
			4'd3:  w = uw(OPA_XM, OPB_XM, 2'd0, ACC_HOLD, ACT_LD_X2, JMP_IF_LIMIT, PC_FIN);
			4'd4:  w = uw(OPA_TERM, OPB_X2, 2'd2, ACC_LOAD, ACT_LD_D, JMP_NEXT, '0);
			4'd5:  w = uw(OPA_TERM, OPB_X2, 2'd1, ACC_MAC, ACT_NONE, JMP_NEXT, '0);
			4'd6:  w = uw(OPA_TERM, OPB_X2, 2'd0, ACC_MAC, ACT_NONE, JMP_NEXT, '0);
			4'd7:  w = uw(OPA_XM, OPB_XM, 2'd0, ACC_HOLD, ACT_LD_DIV, JMP_NEXT, '0);
			4'd8:  w = uw(OPA_XM, OPB_XM, 2'd0, ACC_HOLD, ACT_DIV, JMP_NEXT, '0);
			4'd9:  w = uw(OPA_XM, OPB_XM, 2'd0, ACC_HOLD, ACT_DIV, JMP_NEXT, '0);
			4'd10: w = uw(OPA_XM, OPB_XM, 2'd0, ACC_HOLD, ACT_DIV, JMP_NEXT, '0);
			4'd11: w = uw(OPA_XM, OPB_XM, 2'd0, ACC_HOLD, ACT_DIV, JMP_NEXT, '0);
			4'd12: w = uw(OPA_XM, OPB_XM, 2'd0, ACC_HOLD, ACT_DIV, JMP_NEXT, '0);
			4'd13: w = uw(OPA_XM, OPB_XM, 2'd0, ACC_HOLD, ACT_DIV, JMP_NEXT, '0);
			4'd14: w = uw(OPA_XM, OPB_XM, 2'd0, ACC_HOLD, ACT_TERM, JMP_IF_MORE, PC_LOOP);
			4'd15: w = uw(OPA_XM, OPB_XM, 2'd0, ACC_HOLD, ACT_DONE, JMP_NEXT, '0);
		endcase
		return w;
	endfunction

	always_comb begin
		ctl = busy_q ? ucode(pc_q)
			: uw(OPA_XM, OPB_XM, 2'd0, ACC_HOLD, ACT_NONE, JMP_NEXT, '0);
		taken = ((ctl.jmp == JMP_IF_LIMIT) && stat.limit_hit) ||
			((ctl.jmp == JMP_IF_MORE) && stat.more);
		busy  = busy_q;
		done  = busy_q && (ctl.act == ACT_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= '0;
			busy_q <= 1'b0;
		end else if (!busy_q) begin
			if (start) begin
				pc_q   <= '0;
				busy_q <= 1'b1;
			end
		end else if (ctl.act == ACT_DONE) begin
			if (out_free) begin
				busy_q <= 1'b0;
			end
		end else begin
			pc_q <= taken ? ctl.target : pc_q + PC_W'(1);
		end
	end

	`STS_ASSERT_NXT(a_done_idle, clk, arst_n, done, !busy_q, "sequencer still busy after finish")
	`STS_ASSERT_NXT(a_fin_stall, clk, arst_n, busy_q && (ctl.act == ACT_DONE) && !out_free, busy_q && (pc_q == PC_FIN), "finish step left while result blocked")

endmodule

### hdl/sine_taylor_series.sv
// sine by maclaurin series: top level with stream ports, config registers, result register
// depends on sts_pkg, sts_seq, sts_dp and the assertion macro header
// one angle is in work at a time: a new one is taken only once the last has reached the result register
// each item runs n correction terms on the shared 48x16 multiplier and divider
// (n is about 11 for angles near +-4 at the reset threshold, fewer for small angles)
// reset: arst_n async active low, idle, result empty, threshold 10995, term limit 99
`include "sine_taylor_series_macros.svh"
module sine_taylor_series (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [sts_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sts_pkg::THR_W-1:0]         cfg_data,
	// input stream
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [31:0]                       s_axis_tdata,   // [31:0] angle
	// result stream
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [39:0]                       m_axis_tdata    // [31:0] sine_value,
	                                                          // [38:32] terms_added,
	                                                          // [39] limit_reached
);
	import sts_pkg::*;

	// configuration registers
	logic [THR_W-1:0] thr_q;
	logic [CNT_W-1:0] limit_q;

	// result register, parts the finished result from the next item's work
	logic             m_valid_q;
	logic [39:0]      m_data_q;

	// sequencer and datapath wiring
	ctl_t               ctl;
	stat_t              stat;
	logic               busy;
	logic               done;
	logic               start;
	logic               out_free;
	logic signed [ANGLE_W-1:0] sine_value;
	logic [CNT_W-1:0]   terms_added;
	logic               limit_reached;

	// an item is taken only while the sequencer is idle
	assign s_axis_tready = !busy;
	assign start         = s_axis_tvalid && s_axis_tready;

	// result slot free now or freed by this cycle's transaction
	assign out_free      = !m_valid_q || m_axis_tready;

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= THR_RESET;
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_THRESHOLD: thr_q   <= cfg_data;
				CFG_LIMIT:     limit_q <= cfg_data[CNT_W-1:0];
			endcase
		end
	end

	// valid flag: set when the program finishes, cleared when the result is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (done) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// payload captured on finish, no reset needed
	always_ff @(posedge clk) begin
		if (done) begin
			m_data_q <= {limit_reached, terms_added, sine_value};
		end
	end

	// program counter and control store
	sts_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.out_free (out_free),
		.stat     (stat),
		.ctl      (ctl),
		.busy     (busy),
		.done     (done)
	);

	// multiply, divide, accumulate and saturate
	sts_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.angle          (s_axis_tdata),
		.ctl            (ctl),
		.stop_threshold (thr_q),
		.term_limit     (limit_q),
		.stat           (stat),
		.sine_value     (sine_value),
		.terms_added    (terms_added),
		.limit_reached  (limit_reached)
	);

	`STS_ASSERT_NXT(a_one_in_flight, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second item taken while one is in work")
	`STS_ASSERT_NXT(a_done_shows, clk, arst_n, done, m_axis_tvalid, "finished result not presented")

endmodule

### tb/sine_taylor_series_test.sv
// self-checking testbench for the sine_taylor_series block: stream stimulus, config phases
// depends on sts_pkg (config register indexes and threshold width) and the sine_taylor_series rtl
// a scoreboard class predicts each sine from the accepted angle and checks every result
`timescale 1ns / 100ps
module sine_taylor_series_test;
	import sts_pkg::CFG_IDX_W;
	import sts_pkg::CFG_THRESHOLD;
	import sts_pkg::CFG_LIMIT;
	import sts_pkg::THR_W;

	// number formats of the series, kept apart from the rtl
	localparam int FRAC_INNER = 40;
	localparam int FRAC_IO    = 28;

	// run limits, in clock cycles
	localparam int unsigned CYCLE_LIMIT = 10_000_000;
	localparam int          PHASE_SETTLE = 16;    // idle pause before a register write
	localparam int          FINAL_SETTLE = 1100;  // covers the longest item, at a term limit of 99
	localparam int          HOLD_OFF     = 400;   // long receiver stall under pressure

	// reset values of the two registers
	localparam logic [THR_W-1:0] THR_DEFAULT   = 40'd10995;
	localparam logic [6:0]       LIMIT_DEFAULT = 7'd99;
	localparam logic [THR_W-1:0] THR_MAX       = {THR_W{1'b1}};

	// result transaction, laid out as m_axis_tdata from the top bit down
	typedef struct packed {
		logic       limit_reached;
		logic [6:0] terms_added;
		logic [31:0] sine_value;
	} sine_result_t;

	// scoreboard: predicts the sine of each accepted angle, checks results in order
	class sine_scoreboard;
		logic [THR_W-1:0] threshold;
		logic [6:0]       term_limit;
		// mirror of the series state after the latest item
		logic signed [63:0] last_sum;
		logic signed [63:0] last_term;
		logic [63:0]        last_square;
		logic [6:0]         last_count;
		sine_result_t       expected_sines[$];
		int                 errors;

		function new();
			threshold   = THR_DEFAULT;
			term_limit  = LIMIT_DEFAULT;
			last_sum    = '0;
			last_term   = '0;
			last_square = '0;
			last_count  = '0;
			errors      = 0;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] index, logic [THR_W-1:0] data);
			if (index == CFG_THRESHOLD)
				threshold = data;
			else if (index == CFG_LIMIT)
				term_limit = data[6:0];
		endfunction

		// (a*b) >> FRAC_INNER on magnitudes, full product, truncated
		function logic [63:0] frac_mul(logic [63:0] a, logic [63:0] b);
			logic [127:0] prod;
			prod = {64'd0, a} * {64'd0, b};
			return prod[FRAC_INNER +: 64];
		endfunction

		function sine_result_t series_sine(logic [31:0] raw);
			logic [63:0]        clamp;
			logic [63:0]        mag;
			logic [63:0]        xm;
			logic [63:0]        x2;
			logic [63:0]        tmag;
			logic [63:0]        smag;
			logic [63:0]        divisor;
			logic signed [63:0] sum;
			logic               neg;
			logic               tneg;
			logic               sneg;
			logic               thr_stop;
			int unsigned        n;
			sine_result_t       res;
			clamp = 64'd4 << FRAC_IO;
			neg   = raw[31];
			mag   = neg ? 64'(32'(~raw + 32'd1)) : 64'(raw);
			// angle clamp to [-4, 4)
			if (neg) begin
				if (mag > clamp)
					mag = clamp;
			end else if (mag > clamp - 64'd1) begin
				mag = clamp - 64'd1;
			end
			xm   = mag << (FRAC_INNER - FRAC_IO);
			x2   = frac_mul(xm, xm);
			tmag = xm;
			tneg = neg;
			sum  = neg ? -$signed(xm) : $signed(xm);
			n        = 0;
			thr_stop = 1'b0;
			// each term is the last one times -x^2 / ((2i)(2i+1)), truncated
			while (n < term_limit) begin
				divisor = 64'((2 * (n + 1)) * (2 * (n + 1) + 1));
				tmag    = frac_mul(tmag, x2) / divisor;
				tneg    = !tneg;
				sum     = tneg ? sum - $signed(tmag) : sum + $signed(tmag);
				n++;
				if (tmag <= 64'(threshold)) begin
					thr_stop = 1'b1;
					break;
				end
			end
			last_sum    = sum;
			last_term   = tneg ? -$signed(tmag) : $signed(tmag);
			last_square = x2;
			last_count  = 7'(n);
			// narrow to the io format by truncating the magnitude, then saturate
			sneg = sum[63];
			smag = sneg ? 64'(-sum) : 64'(sum);
			smag = smag >> (FRAC_INNER - FRAC_IO);
			if (sneg) begin
				if (smag > 64'h8000_0000)
					smag = 64'h8000_0000;
				res.sine_value = 32'(64'd0 - smag);
			end else begin
				if (smag > 64'h7FFF_FFFF)
					smag = 64'h7FFF_FFFF;
				res.sine_value = 32'(smag);
			end
			res.terms_added   = 7'(n);
			res.limit_reached = !thr_stop;
			return res;
		endfunction

		function void note_angle(logic [31:0] raw);
			expected_sines.push_back(series_sine(raw));
		endfunction

		function void check_sine(logic [39:0] data);
			sine_result_t got;
			sine_result_t want;
			got = sine_result_t'(data);
			if (expected_sines.size() == 0) begin
				$error("result transaction with no pending angle: tdata %h", data);
				errors++;
				return;
			end
			want = expected_sines.pop_front();
			if (got.sine_value !== want.sine_value) begin
				$error("sine_value: expected %0d, actual %0d",
					$signed(want.sine_value), $signed(got.sine_value));
				errors++;
			end
			if (got.terms_added !== want.terms_added) begin
				$error("terms_added: expected %0d, actual %0d",
					want.terms_added, got.terms_added);
				errors++;
			end
			if (got.limit_reached !== want.limit_reached) begin
				$error("limit_reached: expected %0d, actual %0d",
					want.limit_reached, got.limit_reached);
				errors++;
			end
		endfunction

		function int pending();
			return expected_sines.size();
		endfunction

		function void flag_leftovers();
			if (expected_sines.size() != 0) begin
				$error("%0d expected results never arrived", expected_sines.size());
				errors++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [THR_W-1:0]     cfg_data;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [31:0]          s_axis_tdata;   // [31:0] angle
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [39:0]          m_axis_tdata;   // [31:0] sine_value, [38:32] terms_added,
	                                      // [39] limit_reached

	sine_scoreboard board;
	int unsigned    cycle_count;
	int             send_idle_pct;   // chance per cycle that the sender holds back
	int             stall_pct;       // chance per cycle that the receiver stalls
	int             hold_left;       // cycles of forced receiver stall still to go

	sine_taylor_series u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: a hung block ends the run here
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	// receiver side: random stalls, plus a long forced hold when asked
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// result transactions are checked at the edge that accepts them
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_sine(m_axis_tdata);
	end

	// register write, only called while the block is idle
	task automatic write_register(input logic [CFG_IDX_W-1:0] index,
			input logic [THR_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
		board.write_register(index, data);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// one angle transaction; starts and ends at a falling edge
	task automatic send_angle(input logic [31:0] angle);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= angle;
		do
			@(posedge clk);
		while (!s_axis_tready);
		board.note_angle(s_axis_tdata);
		@(negedge clk);
	endtask

	// sender pauses until every expected sine has come back
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(negedge clk);
	endtask

	// random angle: full 32-bit words, in-range values, values around the clamp, tiny values
	function automatic logic [31:0] pick_angle();
		logic [31:0] r;
		int unsigned k;
		r = $urandom;
		k = $urandom_range(9);
		case (k)
			4, 5, 6: pick_angle = {{2{r[30]}}, r[29:0]};
			7: pick_angle = ($urandom_range(1) ? 32'h4000_0000 : 32'hC000_0000)
				+ 32'($urandom_range(8)) - 32'd4;
			8: begin
				r = r >> $urandom_range(31);
				pick_angle = $urandom_range(1) ? -r : r;
			end
			default: pick_angle = r;
		endcase
	endfunction

	// idling mix for a phase: none, sender idle, receiver stalls, both
	task automatic set_idling(input int mode);
		case (mode)
			1: begin send_idle_pct = 56; stall_pct = 0;  end
			2: begin send_idle_pct = 0;  stall_pct = 56; end
			3: begin send_idle_pct = 35; stall_pct = 35; end
			default: begin send_idle_pct = 0; stall_pct = 0; end
		endcase
	endtask

	// directed angles: zero, lsb steps, clamp edges, +-pi/2, alternating bit patterns
	logic [31:0] directed_angles[18] = '{
		32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h1000_0000,
		32'hF000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h4000_0000,
		32'hC000_0000, 32'h3FFF_FFFF, 32'hC000_0001, 32'h4000_0001,
		32'hBFFF_FFFF, 32'h1921_FB54, 32'hE6DE_04AC, 32'h5555_5555,
		32'hAAAA_AAAA, 32'h0000_0100
	};

	initial begin
		logic [THR_W-1:0] thr;
		logic [6:0]       lim;
		int               count;
		board         = new();
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_left     = 0;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: directed angles first, then random ones
		set_idling(0);
		foreach (directed_angles[i])
			send_angle(directed_angles[i]);
		for (int i = 0; i < 160; i++) begin
			if (i == 80)
				set_idling(3);
			send_angle(pick_angle());
		end

		// register settings, extremes first, then random ones
		for (int s = 1; s <= 9; s++) begin
			wait_drained();
			repeat (PHASE_SETTLE) @(negedge clk);
			count = 160;
			case (s)
				1: begin thr = '0;          lim = LIMIT_DEFAULT; end
				2: begin thr = THR_MAX;     lim = LIMIT_DEFAULT; end
				3: begin thr = THR_DEFAULT; lim = 7'd1;          end
				4: begin thr = '0;          lim = 7'd1;          end
				// limit reached on the first term, with the threshold also met there for small angles
				5: begin thr = THR_MAX;     lim = 7'd1;          end
				// no correction term at all: result is the clamped angle itself
				6: begin thr = THR_DEFAULT; lim = 7'd0; count = 60; end
				7: begin
					thr = {8'($urandom_range(255)), 32'($urandom)};
					lim = 7'($urandom_range(99, 1));
				end
				8: begin
					thr = 40'($urandom_range(32'h000F_FFFF));
					lim = 7'($urandom_range(12, 2));
				end
				default: begin thr = THR_DEFAULT; lim = LIMIT_DEFAULT; end
			endcase
			write_register(CFG_THRESHOLD, thr);
			write_register(CFG_LIMIT, 40'(lim));
			set_idling(s % 4);
			for (int i = 0; i < count; i++) begin
				// pressure: long receiver hold while angles keep coming, then a full drain
				if (s == 8 && i == 40)
					hold_left = HOLD_OFF;
				if (s == 8 && i == 100)
					wait_drained();
				send_angle(pick_angle());
			end
		end

		wait_drained();
		repeat (FINAL_SETTLE) @(negedge clk);
		board.flag_leftovers();
		if (board.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### sim.f
+incdir+hdl
hdl/sts_pkg.sv
hdl/sts_dp.sv
hdl/sts_seq.sv
hdl/sine_taylor_series.sv
tb/sine_taylor_series_test.sv
